### sv/tgpr_pkg.sv
// ----------------------------------------------------------------------------
// Text glyph pixel renderer package
// Shared constants, the queue entry type and the 5x8 font table.
// ----------------------------------------------------------------------------
package tgpr_pkg;

    // Panel and font geometry.
    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_ROWS   = 64;
    localparam int GLYPH_COUNT  = 96;
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 8;
    localparam int GLYPH_PIXELS = GLYPH_COLS * GLYPH_ROWS;
    localparam logic [7:0] FIRST_CODE = 8'h20;

    // Register map, decoded on the word address bit.
    localparam int PADDR_WIDTH = 3;
    localparam logic REG_START_ROW    = 1'b0;
    localparam logic REG_START_COLUMN = 1'b1;

    // Queue between the front and back parts (power of two depth).
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One classified character waiting to be drawn.
    typedef struct packed {
        logic [7:0] row;
        logic [7:0] column;
        logic [6:0] glyph;
        logic       printable;
    } tgpr_job_t;

    // Glyph bitmap: column 0 in the top byte, bit r of a byte is row r.
    function automatic logic [GLYPH_PIXELS-1:0] font_glyph(input logic [6:0] idx);
        logic [GLYPH_PIXELS-1:0] g;
        begin
            case (idx)
                7'd0:  g = 40'h00_00_00_00_00;
                7'd1:  g = 40'h00_00_5f_00_00;
                7'd2:  g = 40'h00_07_00_07_00;
                7'd3:  g = 40'h14_7f_14_7f_14;
                7'd4:  g = 40'h24_2a_7f_2a_12;
                7'd5:  g = 40'h23_13_08_64_62;
                7'd6:  g = 40'h36_49_55_22_50;
                7'd7:  g = 40'h00_05_03_00_00;
                7'd8:  g = 40'h00_1c_22_41_00;
                7'd9:  g = 40'h00_41_22_1c_00;
                7'd10: g = 40'h14_08_3e_08_14;
                7'd11: g = 40'h08_08_3e_08_08;
                7'd12: g = 40'h00_50_30_00_00;
                7'd13: g = 40'h08_08_08_08_08;
                7'd14: g = 40'h00_60_60_00_00;
                7'd15: g = 40'h20_10_08_04_02;
                7'd16: g = 40'h3e_51_49_45_3e;
                7'd17: g = 40'h00_42_7f_40_00;
                7'd18: g = 40'h42_61_51_49_46;
                7'd19: g = 40'h21_41_45_4b_31;
                7'd20: g = 40'h18_14_12_7f_10;
                7'd21: g = 40'h27_45_45_45_39;
                7'd22: g = 40'h3c_4a_49_49_30;
                7'd23: g = 40'h01_71_09_05_03;
                7'd24: g = 40'h36_49_49_49_36;
                7'd25: g = 40'h06_49_49_29_1e;
                7'd26: g = 40'h00_36_36_00_00;
                7'd27: g = 40'h00_56_36_00_00;
                7'd28: g = 40'h08_14_22_41_00;
                7'd29: g = 40'h14_14_14_14_14;
                7'd30: g = 40'h00_41_22_14_08;
                7'd31: g = 40'h02_01_51_09_06;
                7'd32: g = 40'h32_49_79_41_3e;
                7'd33: g = 40'h7e_11_11_11_7e;
                7'd34: g = 40'h7f_49_49_49_36;
                7'd35: g = 40'h3e_41_41_41_22;
                7'd36: g = 40'h7f_41_41_22_1c;
                7'd37: g = 40'h7f_49_49_49_41;
                7'd38: g = 40'h7f_09_09_09_01;
                7'd39: g = 40'h3e_41_49_49_7a;
                7'd40: g = 40'h7f_08_08_08_7f;
                7'd41: g = 40'h00_41_7f_41_00;
                7'd42: g = 40'h20_40_41_3f_01;
                7'd43: g = 40'h7f_08_14_22_41;
                7'd44: g = 40'h7f_40_40_40_40;
                7'd45: g = 40'h7f_02_0c_02_7f;
                7'd46: g = 40'h7f_04_08_10_7f;
                7'd47: g = 40'h3e_41_41_41_3e;
                7'd48: g = 40'h7f_09_09_09_06;
                7'd49: g = 40'h3e_41_51_21_5e;
                7'd50: g = 40'h7f_09_19_29_46;
                7'd51: g = 40'h46_49_49_49_31;
                7'd52: g = 40'h01_01_7f_01_01;
                7'd53: g = 40'h3f_40_40_40_3f;
                7'd54: g = 40'h1f_20_40_20_1f;
                7'd55: g = 40'h3f_40_38_40_3f;
                7'd56: g = 40'h63_14_08_14_63;
                7'd57: g = 40'h07_08_70_08_07;
                7'd58: g = 40'h61_51_49_45_43;
                7'd59: g = 40'h00_7f_41_41_00;
                7'd60: g = 40'h02_04_08_10_20;
                7'd61: g = 40'h00_41_41_7f_00;
                7'd62: g = 40'h04_02_01_02_04;
                7'd63: g = 40'h40_40_40_40_40;
                7'd64: g = 40'h00_01_02_04_00;
                7'd65: g = 40'h20_54_54_54_78;
                7'd66: g = 40'h7f_48_44_44_38;
                7'd67: g = 40'h38_44_44_44_20;
                7'd68: g = 40'h38_44_44_48_7f;
                7'd69: g = 40'h38_54_54_54_18;
                7'd70: g = 40'h08_7e_09_01_02;
                7'd71: g = 40'h0c_52_52_52_3e;
                7'd72: g = 40'h7f_08_04_04_78;
                7'd73: g = 40'h00_44_7d_40_00;
                7'd74: g = 40'h20_40_44_3d_00;
                7'd75: g = 40'h7f_10_28_44_00;
                7'd76: g = 40'h00_41_7f_40_00;
                7'd77: g = 40'h7c_04_18_04_78;
                7'd78: g = 40'h7c_08_04_04_78;
                7'd79: g = 40'h38_44_44_44_38;
                7'd80: g = 40'h7c_14_14_14_08;
                7'd81: g = 40'h08_14_14_18_7c;
                7'd82: g = 40'h7c_08_04_04_08;
                7'd83: g = 40'h48_54_54_54_20;
                7'd84: g = 40'h04_3f_44_40_20;
                7'd85: g = 40'h3c_40_40_20_7c;
                7'd86: g = 40'h1c_20_40_20_1c;
                7'd87: g = 40'h3c_40_30_40_3c;
                7'd88: g = 40'h44_28_10_28_44;
                7'd89: g = 40'h0c_50_50_50_3c;
                7'd90: g = 40'h44_64_54_4c_44;
                7'd91: g = 40'h00_08_36_41_00;
                7'd92: g = 40'h00_00_7f_00_00;
                7'd93: g = 40'h00_41_36_08_00;
                7'd94: g = 40'h10_08_08_10_08;
                7'd95: g = 40'h00_06_09_09_06;
                default: g = '0;
            endcase
            return g;
        end
    endfunction

endpackage

### sv/tgpr_front.sv
// ----------------------------------------------------------------------------
// Text glyph pixel renderer front part
// Accepts characters, classifies them and advances the text cursor.
// ----------------------------------------------------------------------------
module tgpr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          char_code,
    input  logic                first_of_message,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [5:0]          start_row,
    input  logic [6:0]          start_column,
    input  logic                q_full,
    output logic                q_push,
    output tgpr_pkg::tgpr_job_t q_wdata
);
    import tgpr_pkg::*;

    logic [7:0] cursor_row_reg;
    logic [7:0] cursor_row_next;
    logic [7:0] cursor_column_reg;
    logic [7:0] cursor_column_next;
    logic [7:0] base_row;
    logic [7:0] base_column;
    logic [7:0] advanced_column;
    logic [8:0] glyph_end;
    logic       wrap;
    logic       printable;

    // A transfer is taken whenever the queue has room.
    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    // Cursor start point: reload from the start registers on a new message.
    assign base_row    = first_of_message ? {2'b00, start_row} : cursor_row_reg;
    assign base_column = first_of_message ? {1'b0, start_column} : cursor_column_reg;

    // Advance before drawing, then wrap to the next text line if needed.
    assign advanced_column = base_column + 8'(GLYPH_COLS);
    assign glyph_end       = {1'b0, advanced_column} + 9'(GLYPH_COLS);
    assign wrap            = glyph_end >= 9'(PANEL_WIDTH);

    always_comb
    begin
        cursor_row_next    = wrap ? base_row + 8'(GLYPH_ROWS) : base_row;
        cursor_column_next = wrap ? {1'b0, start_column} : advanced_column;
    end

    // Printable codes are 0x20 through 0x7F.
    assign printable = (char_code[7] == 1'b0) && (char_code[6:5] != 2'b00);

    always_comb
    begin
        q_wdata.row       = cursor_row_next;
        q_wdata.column    = cursor_column_next;
        q_wdata.glyph     = char_code[6:0] - FIRST_CODE[6:0];
        q_wdata.printable = printable;
    end

    // Cursor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg    <= '0;
            cursor_column_reg <= '0;
        end
        else if (q_push)
        begin
            cursor_row_reg    <= cursor_row_next;
            cursor_column_reg <= cursor_column_next;
        end
    end

endmodule

### sv/tgpr_queue.sv
// ----------------------------------------------------------------------------
// Text glyph pixel renderer job queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module tgpr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tgpr_pkg::tgpr_job_t wdata,
    input  logic                pop,
    output tgpr_pkg::tgpr_job_t rdata,
    output logic                full,
    output logic                empty
);
    import tgpr_pkg::*;

    tgpr_job_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full  = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers wrap naturally since the depth is a power of two.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/tgpr_back.sv
// ----------------------------------------------------------------------------
// Text glyph pixel renderer back part
// Walks a glyph column by column and registers one pixel write per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module tgpr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  tgpr_pkg::tgpr_job_t q_rdata,
    output logic                q_pop,
    output logic [7:0]          pixel_row,
    output logic [7:0]          pixel_column,
    output logic                pixel_on,
    output logic                off_panel,
    output logic                last_pixel,
    output logic                out_valid,
    input  logic                out_ready
);
    import tgpr_pkg::*;

    localparam int PIX_W = $clog2(GLYPH_PIXELS);

    logic                    active_reg;
    logic [PIX_W-1:0]        pix_reg;
    logic [7:0]              job_row_reg;
    logic [7:0]              job_column_reg;
    logic [GLYPH_PIXELS-1:0] bits_reg;
    logic                    out_valid_reg;
    logic [7:0]              pixel_row_reg;
    logic [7:0]              pixel_column_reg;
    logic                    pixel_on_reg;
    logic                    off_panel_reg;
    logic                    last_pixel_reg;

    logic                    advance;
    logic                    finishing;
    logic [2:0]              glyph_col;
    logic [2:0]              glyph_row;
    logic [7:0]              column_bits;
    logic [8:0]              row_full;
    logic [8:0]              column_full;
    logic                    is_last;

    // The output register moves whenever it is empty or being taken.
    assign advance   = !out_valid_reg || out_ready;
    assign is_last   = pix_reg == PIX_W'(GLYPH_PIXELS - 1);
    assign finishing = active_reg && advance && is_last;
    assign q_pop     = !q_empty && (!active_reg || finishing);

    // Pixel position inside the glyph: column in the upper bits, row below.
    assign glyph_col = pix_reg[PIX_W-1:3];
    assign glyph_row = pix_reg[2:0];

    always_comb
    begin
        case (glyph_col)
            3'd0:    column_bits = bits_reg[39:32];
            3'd1:    column_bits = bits_reg[31:24];
            3'd2:    column_bits = bits_reg[23:16];
            3'd3:    column_bits = bits_reg[15:8];
            default: column_bits = bits_reg[7:0];
        endcase
    end

    // Bounds are judged on the unwrapped position.
    assign row_full    = {1'b0, job_row_reg} + {6'b0, glyph_row};
    assign column_full = {1'b0, job_column_reg} + {6'b0, glyph_col};

    // Sequencing control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= active_reg;
            end
            if (q_pop)
            begin
                active_reg <= 1'b1;
                pix_reg    <= '0;
            end
            else if (finishing)
            begin
                active_reg <= 1'b0;
            end
            else if (active_reg && advance)
            begin
                pix_reg <= pix_reg + 1'b1;
            end
        end
    end

    // Job and pixel payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_row_reg    <= q_rdata.row;
            job_column_reg <= q_rdata.column;
            bits_reg       <= q_rdata.printable ? font_glyph(q_rdata.glyph) : '0;
        end
        if (advance && active_reg)
        begin
            pixel_row_reg    <= row_full[7:0];
            pixel_column_reg <= column_full[7:0];
            pixel_on_reg     <= column_bits[glyph_row];
            off_panel_reg    <= (row_full >= 9'(PANEL_ROWS)) ||
                                (column_full >= 9'(PANEL_WIDTH));
            last_pixel_reg   <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_row    = pixel_row_reg;
    assign pixel_column = pixel_column_reg;
    assign pixel_on     = pixel_on_reg;
    assign off_panel    = off_panel_reg;
    assign last_pixel   = last_pixel_reg;

endmodule

### sv/text_glyph_pixel_renderer_unit.sv
// ----------------------------------------------------------------------------
// Text glyph pixel renderer
// Draws 5x8 font characters as a stream of pixel writes on a text cursor.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one character per transfer
//   with a first_of_message flag that reloads the cursor from start_row and
//   start_column. The output channel (out_valid/out_ready) carries 40 pixel
//   writes per character, column by column and rows 0 to 7 inside each
//   column, with last_pixel marking the final write of the glyph.
//   When the drawing unit is idle, a character passes through the queue
//   entry, the sequencer and the output register before its first pixel write.
//   Throughput: one pixel write per cycle while the receiver does not stall;
//   the rate is set by the single pixel sequencer in the back part. A
//   two-entry queue lets the input take characters while a glyph is drawn.
//   When the receiver stalls, the current pixel write holds in the output
//   register and the sequencer waits; the input stops once the queue fills.
//   Reset clears the cursor, start registers, queue and sequencer. Start
//   registers must be written via the APB port while idle (not enforced).
// ----------------------------------------------------------------------------
module text_glyph_pixel_renderer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tgpr_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic [7:0]                       char_code,
    input  logic                             first_of_message,
    input  logic                             in_valid,
    output logic                             in_ready,
    output logic [7:0]                       pixel_row,
    output logic [7:0]                       pixel_column,
    output logic                             pixel_on,
    output logic                             off_panel,
    output logic                             last_pixel,
    output logic                             out_valid,
    input  logic                             out_ready
);
    import tgpr_pkg::*;

    logic [5:0] start_row_reg;
    logic [6:0] start_column_reg;
    logic       cfg_write;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    tgpr_job_t  q_wdata;
    tgpr_job_t  q_rdata;

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg    <= '0;
            start_column_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_START_ROW:    start_row_reg    <= pwdata[5:0];
                REG_START_COLUMN: start_column_reg <= pwdata[6:0];
                default:          start_row_reg    <= start_row_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_START_ROW:    prdata = {26'b0, start_row_reg};
            REG_START_COLUMN: prdata = {25'b0, start_column_reg};
            default:          prdata = '0;
        endcase
    end

    // Front part: accepts and classifies characters.
    tgpr_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .char_code        (char_code),
        .first_of_message (first_of_message),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .start_row        (start_row_reg),
        .start_column     (start_column_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_wdata          (q_wdata)
    );

    // Queue between the two parts.
    tgpr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // Back part: draws the glyph.
    tgpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .pixel_on     (pixel_on),
        .off_panel    (off_panel),
        .last_pixel   (last_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

    // A glyph keeps streaming until its last pixel write is transferred.
    a_glyph_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_pixel) |=> out_valid)
        else $error("pixel stream broke off inside a glyph");

    // An accepted character is held in the queue or already being drawn.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !q_empty || out_valid)
        else $error("accepted character lost before drawing");

    // A start row write takes the written value.
    a_start_row_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && paddr[2] == REG_START_ROW) |=> start_row_reg == $past(pwdata[5:0]))
        else $error("start row register not updated");

endmodule
